>>> rtl/sdhr_pkg.sv
// ----------------------------------------------------------------------------
// SD host register bank package
// Item types, register word indices and reset values shared by the block.
// ----------------------------------------------------------------------------
package sdhr_pkg;

  localparam int unsigned ADDR_W    = 10;
  localparam int unsigned DIV_W     = 24;
  localparam int unsigned FDIV_W    = 8;
  localparam int unsigned WDOG_W    = 16;
  localparam int unsigned CMD8_W    = 14;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CRC_W     = 7;

  localparam logic [ADDR_W-1:0] ADDR_DIVIDER  = 10'd0;
  localparam logic [ADDR_W-1:0] ADDR_CONTROL  = 10'd1;
  localparam logic [ADDR_W-1:0] ADDR_WATCHDOG = 10'd2;
  localparam logic [ADDR_W-1:0] ADDR_STATUS   = 10'd4;
  localparam logic [ADDR_W-1:0] ADDR_LAST_CMD = 10'd5;
  localparam logic [ADDR_W-1:0] ADDR_LAST_ARG = 10'd6;
  localparam logic [ADDR_W-1:0] ADDR_CMD8     = 10'd8;

  localparam logic [WDOG_W-1:0] WATCHDOG_RESET  = 16'h0FFF;
  localparam logic [CMD8_W-1:0] CMD8_RESET      = 14'h0155;
  localparam logic [IDX_W-1:0]  REQ_INDEX_RESET = '1;

  typedef struct packed {
    logic              req_valid;
    logic              req_write;
    logic [ADDR_W-1:0] req_word_addr;
    logic [31:0]       req_wdata;
    logic              cmd_req_valid;
    logic [IDX_W-1:0]  cmd_req_index;
    logic              cmd_resp_valid;
    logic [IDX_W-1:0]  cmd_resp_index;
    logic [31:0]       cmd_resp_arg;
    logic [13:0]       resp_crc_pair;
    logic              slow_clock_select;
    logic [11:0]       card_status;
  } in_item_t;

  typedef struct packed {
    logic              bus_ack;
    logic [31:0]       bus_rdata;
    logic              card_clock;
    logic              clock_rise_strobe;
    logic              clock_fall_strobe;
    logic [WDOG_W-1:0] watchdog_limit;
    logic              error_clear;
    logic              spi_select;
    logic              low_voltage_request;
    logic              pcie_request;
    logic [3:0]        supply_range;
    logic [7:0]        echo_pattern;
  } out_item_t;

endpackage

>>> rtl/sdhr_if.sv
// ----------------------------------------------------------------------------
// SD host register bank channels
// Valid/ready channels for the cycle items and the result items.
// ----------------------------------------------------------------------------
interface sdhr_in_if;
  logic              valid;
  logic              ready;
  sdhr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdhr_out_if;
  logic               valid;
  logic               ready;
  sdhr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sd_host_register_bank_clock_divider_top.sv
// ----------------------------------------------------------------------------
// SD host register bank with card clock divider
// Throughput: one item per cycle while the output is not blocked, set by the single-pass register bank stage.
// Reset: synchronous; registers take their documented values, stages empty.
// ----------------------------------------------------------------------------
module sd_host_register_bank_clock_divider_top (
  input  logic       clk,
  input  logic       rst_n,
  sdhr_in_if.sink    in_ch,
  sdhr_out_if.source out_ch
);

  logic                stage_valid;
  sdhr_pkg::in_item_t  stage_item;
  sdhr_pkg::out_item_t core_res;
  logic                advance;
  logic                out_valid_r;
  logic                out_valid_nxt;
  sdhr_pkg::out_item_t out_item_r;

  assign advance       = stage_valid && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  sdhr_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  sdhr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (stage_item),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= core_res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // A consumed item always leaves a result in the output register.
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register empty after an item was consumed");

  // The input side stalls only when both stages are full and the output is blocked.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && !in_ch.ready) |-> (stage_valid && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> !(core_res.clock_rise_strobe && core_res.clock_fall_strobe))
    else $error("card clock rise and fall strobes together");

endmodule

>>> rtl/sdhr_in_reg.sv
// ----------------------------------------------------------------------------
// SD host register bank input stage
// Holds one accepted item until the register bank consumes it.
// ----------------------------------------------------------------------------
module sdhr_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  sdhr_in_if.sink            in_ch,
  input  logic               advance,
  output logic               stage_valid,
  output sdhr_pkg::in_item_t stage_item
);

  logic               valid_r;
  logic               valid_nxt;
  sdhr_pkg::in_item_t item_r;
  logic               take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = take || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_ch.data;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

>>> rtl/sdhr_core.sv
// ----------------------------------------------------------------------------
// SD host register bank core
// Bus registers, command snapshots and card clock divider for one cycle item.
// ----------------------------------------------------------------------------
module sdhr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  sdhr_pkg::in_item_t  item,
  output sdhr_pkg::out_item_t result
);

  logic                          clock_enable_r, clock_enable_nxt;
  logic                          spi_flag_r, spi_flag_nxt;
  logic                          clear_pulse_r, clear_pulse_nxt;
  logic [sdhr_pkg::DIV_W-1:0]    slow_divider_r, slow_divider_nxt;
  logic [sdhr_pkg::FDIV_W-1:0]   fast_divider_r, fast_divider_nxt;
  logic [sdhr_pkg::DIV_W-1:0]    divide_count_r, divide_count_nxt;
  logic [sdhr_pkg::WDOG_W-1:0]   watchdog_r, watchdog_nxt;
  logic                          clock_level_r, clock_level_nxt;
  logic                          read_valid_r, read_valid_nxt;
  logic [31:0]                   read_data_r, read_data_nxt;
  logic [sdhr_pkg::IDX_W-1:0]    req_index_r, req_index_nxt;
  logic [sdhr_pkg::IDX_W-1:0]    resp_index_r, resp_index_nxt;
  logic [sdhr_pkg::CRC_W-1:0]    crc_rx_r, crc_rx_nxt;
  logic [sdhr_pkg::CRC_W-1:0]    crc_calc_r, crc_calc_nxt;
  logic [31:0]                   resp_arg_r, resp_arg_nxt;
  logic [sdhr_pkg::CMD8_W-1:0]   cmd8_r, cmd8_nxt;

  logic                          do_write;
  logic [sdhr_pkg::DIV_W-1:0]    limit;
  logic                          toggle;

  assign do_write = item.req_valid && item.req_write;
  assign limit    = item.slow_clock_select ? slow_divider_r
                                           : {{(sdhr_pkg::DIV_W-sdhr_pkg::FDIV_W){1'b0}},
                                              fast_divider_r};
  assign toggle   = clock_enable_r && (divide_count_r >= limit);

  always_comb begin
    clock_enable_nxt = clock_enable_r;
    spi_flag_nxt     = spi_flag_r;
    clear_pulse_nxt  = 1'b0;
    slow_divider_nxt = slow_divider_r;
    fast_divider_nxt = fast_divider_r;
    watchdog_nxt     = watchdog_r;
    cmd8_nxt         = cmd8_r;
    read_valid_nxt   = item.req_valid;
    read_data_nxt    = '0;
    clock_level_nxt  = clock_level_r;
    divide_count_nxt = divide_count_r;

    if (toggle) begin
      divide_count_nxt = '0;
      clock_level_nxt  = !clock_level_r;
    end else if (clock_enable_r) begin
      divide_count_nxt = divide_count_r + 1'b1;
    end

    unique case (item.req_word_addr)
      sdhr_pkg::ADDR_DIVIDER: begin
        read_data_nxt = {fast_divider_r, slow_divider_r};
        if (do_write) begin
          fast_divider_nxt = item.req_wdata[31:24];
          slow_divider_nxt = item.req_wdata[23:0];
          divide_count_nxt = '0;
        end
      end
      sdhr_pkg::ADDR_CONTROL: begin
        read_data_nxt = {23'd0, item.card_status[4:0], spi_flag_r, 2'b00, clock_enable_r};
        if (do_write) begin
          clock_enable_nxt = item.req_wdata[0];
          clear_pulse_nxt  = item.req_wdata[1];
          spi_flag_nxt     = item.req_wdata[3];
        end
      end
      sdhr_pkg::ADDR_WATCHDOG: begin
        read_data_nxt = {16'd0, watchdog_r};
        if (do_write) begin
          watchdog_nxt = item.req_wdata[15:0];
        end
      end
      sdhr_pkg::ADDR_STATUS: begin
        read_data_nxt = {17'd0, item.card_status[11:9], 8'd0, item.card_status[8:5]};
      end
      sdhr_pkg::ADDR_LAST_CMD: begin
        read_data_nxt = {1'b0, crc_calc_r, 1'b0, crc_rx_r, 2'b00, resp_index_r,
                         2'b00, req_index_r};
      end
      sdhr_pkg::ADDR_LAST_ARG: begin
        read_data_nxt = resp_arg_r;
      end
      sdhr_pkg::ADDR_CMD8: begin
        read_data_nxt = {18'd0, cmd8_r};
        if (do_write) begin
          cmd8_nxt = item.req_wdata[13:0];
        end
      end
      default: begin
        read_data_nxt = '0;
      end
    endcase
  end

  assign req_index_nxt  = item.cmd_req_valid ? item.cmd_req_index : req_index_r;
  assign resp_index_nxt = item.cmd_resp_valid ? item.cmd_resp_index : resp_index_r;
  assign crc_rx_nxt     = item.cmd_resp_valid ? item.resp_crc_pair[13:7] : crc_rx_r;
  assign crc_calc_nxt   = item.cmd_resp_valid ? item.resp_crc_pair[6:0] : crc_calc_r;
  assign resp_arg_nxt   = item.cmd_resp_valid ? item.cmd_resp_arg : resp_arg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_enable_r <= 1'b0;
      spi_flag_r     <= 1'b0;
      clear_pulse_r  <= 1'b0;
      slow_divider_r <= '0;
      fast_divider_r <= '0;
      divide_count_r <= '0;
      watchdog_r     <= sdhr_pkg::WATCHDOG_RESET;
      clock_level_r  <= 1'b0;
      read_valid_r   <= 1'b0;
      read_data_r    <= '0;
      req_index_r    <= sdhr_pkg::REQ_INDEX_RESET;
      resp_index_r   <= '0;
      crc_rx_r       <= '0;
      crc_calc_r     <= '0;
      resp_arg_r     <= '0;
      cmd8_r         <= sdhr_pkg::CMD8_RESET;
    end else if (step) begin
      clock_enable_r <= clock_enable_nxt;
      spi_flag_r     <= spi_flag_nxt;
      clear_pulse_r  <= clear_pulse_nxt;
      slow_divider_r <= slow_divider_nxt;
      fast_divider_r <= fast_divider_nxt;
      divide_count_r <= divide_count_nxt;
      watchdog_r     <= watchdog_nxt;
      clock_level_r  <= clock_level_nxt;
      read_valid_r   <= read_valid_nxt;
      read_data_r    <= read_data_nxt;
      req_index_r    <= req_index_nxt;
      resp_index_r   <= resp_index_nxt;
      crc_rx_r       <= crc_rx_nxt;
      crc_calc_r     <= crc_calc_nxt;
      resp_arg_r     <= resp_arg_nxt;
      cmd8_r         <= cmd8_nxt;
    end
  end

  always_comb begin
    result.bus_ack             = read_valid_r;
    result.bus_rdata           = read_data_r;
    result.card_clock          = clock_level_r;
    result.clock_rise_strobe   = toggle && !clock_level_r;
    result.clock_fall_strobe   = toggle && clock_level_r;
    result.watchdog_limit      = watchdog_r;
    result.error_clear         = clear_pulse_r;
    result.spi_select          = spi_flag_r;
    result.low_voltage_request = cmd8_r[13];
    result.pcie_request        = cmd8_r[12];
    result.supply_range        = cmd8_r[11:8];
    result.echo_pattern        = cmd8_r[7:0];
  end

endmodule
